// ===== hdl/ggd_pkg.sv =====
// Shared types and constants for the grid gradient and divergence block.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
package ggd_pkg;

	localparam int ROW_W    = 12;
	localparam int COL_W    = 6;
	localparam int GRAD_W   = 24;
	localparam int DIV_W    = 25;
	localparam int ROWCNT_W = 13;
	localparam int RECIP_W  = 16;
	localparam int MAX_ROWS = 4096;
	localparam int FRAC_SH  = 8;

	localparam int        ADDR_W = 4;
	localparam int        DATA_W = 32;
	localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] REG_RECIP_X      = 2'd2;
	localparam logic [1:0] REG_RECIP_Y      = 2'd3;

	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 13'd2;
	localparam logic [COL_W-1:0]    COL_COUNT_RST = 6'd2;
	localparam logic [RECIP_W-1:0]  RECIP_RST     = 16'd256;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             take;
		logic             rd_y;
		logic             rd_x;
		logic             dif;
		logic             mul;
		logic             load;
		logic             wr;
		logic             flush;
		logic             row_one;
		logic             row_par;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] ncols;
	} ggd_cmd_t;

endpackage

// ===== hdl/ggd_if.sv =====
// Valid/ready stream interfaces for grid samples and gradient results.
// Depends on ggd_pkg for the result field widths.
interface ggd_in_if #(parameter int SAMPLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface ggd_out_if;
	logic                            valid;
	logic                            ready;
	logic [ggd_pkg::ROW_W-1:0]       out_row;
	logic [ggd_pkg::COL_W-1:0]       out_col;
	logic signed [ggd_pkg::GRAD_W-1:0] grad_x;
	logic signed [ggd_pkg::GRAD_W-1:0] grad_y;
	logic signed [ggd_pkg::DIV_W-1:0]  div_sum;
	logic                            run_last;

	modport source (output valid, output out_row, output out_col, output grad_x,
		output grad_y, output div_sum, output run_last, input ready);
	modport sink (input valid, input out_row, input out_col, input grad_x,
		input grad_y, input div_sum, input run_last, output ready);
endinterface

// ===== hdl/ggd_ctrl.sv =====
// Sequencer for the gradient block: raster position, clamping of the counts,
// and the per-point command sequence including the final-row flush.
// Depends on ggd_pkg.
module ggd_ctrl #(
	parameter int COLS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ggd_pkg::ROWCNT_W-1:0]   row_count,
	input  logic [ggd_pkg::COL_W-1:0]      column_count,
	input  logic                           out_free,
	output ggd_pkg::ggd_cmd_t              cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDY  = 3'd1;
	localparam logic [2:0] S_RDX  = 3'd2;
	localparam logic [2:0] S_DIF  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;

	logic [2:0]                      state_q;
	logic [ggd_pkg::ROW_W-1:0]       row_pos_q;
	logic [ggd_pkg::COL_W-1:0]       col_pos_q;
	logic [ggd_pkg::ROW_W-1:0]       r_q;
	logic [ggd_pkg::COL_W-1:0]       c_q;
	logic [ggd_pkg::COL_W-1:0]       ncols_q;
	logic                            fl_q;
	logic                            fpt_q;

	logic [ggd_pkg::ROWCNT_W-1:0]    nrows;
	logic [ggd_pkg::COL_W-1:0]       ncols;
	logic [ggd_pkg::COL_W-1:0]       j_cl;
	logic                            last_row;
	logic                            last_col;
	logic                            accept;
	logic                            col_end;

	assign nrows = (row_count < 13'd2) ? 13'd2 :
		(row_count > 13'(ggd_pkg::MAX_ROWS)) ? 13'(ggd_pkg::MAX_ROWS) : row_count;
	assign ncols = (column_count < 6'd2) ? 6'd2 :
		(column_count > 6'(COLS)) ? 6'(COLS) : column_count;
	assign j_cl     = (col_pos_q > 6'(COLS - 1)) ? 6'(COLS - 1) : col_pos_q;
	assign last_row = {1'b0, row_pos_q} >= (nrows - 13'd1);
	assign last_col = col_pos_q >= (ncols - 6'd1);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign col_end  = (c_q == ncols_q - 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_pos_q <= '0;
			col_pos_q <= '0;
			r_q       <= '0;
			c_q       <= '0;
			ncols_q   <= 6'd2;
			fl_q      <= 1'b0;
			fpt_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						r_q     <= row_pos_q;
						c_q     <= j_cl;
						ncols_q <= ncols;
						fl_q    <= last_col && last_row;
						fpt_q   <= 1'b0;
						if (last_col) begin
							col_pos_q <= '0;
							row_pos_q <= last_row ? '0 : row_pos_q + 12'd1;
						end else begin
							col_pos_q <= j_cl + 6'd1;
						end
						state_q <= (row_pos_q != '0) ? S_RDY : S_WR;
					end
				end
				S_RDY: state_q <= S_RDX;
				S_RDX: state_q <= S_DIF;
				S_DIF: state_q <= S_MUL;
				S_MUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (!fpt_q) begin
							state_q <= S_WR;
						end else if (col_end) begin
							state_q <= S_IDLE;
						end else begin
							c_q     <= c_q + 6'd1;
							state_q <= S_RDY;
						end
					end
				end
				S_WR: begin
					if (fl_q) begin
						fpt_q   <= 1'b1;
						c_q     <= '0;
						state_q <= S_RDY;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.take    = accept;
		cmd.rd_y    = (state_q == S_RDY);
		cmd.rd_x    = (state_q == S_RDX);
		cmd.dif     = (state_q == S_DIF);
		cmd.mul     = (state_q == S_MUL);
		cmd.load    = (state_q == S_OUT) && out_free;
		cmd.wr      = (state_q == S_WR);
		cmd.flush   = fpt_q;
		cmd.row_one = (r_q == 12'd1);
		cmd.row_par = r_q[0];
		cmd.last    = fpt_q ? col_end : !fl_q;
		cmd.row     = fpt_q ? r_q : r_q - 12'd1;
		cmd.col     = c_q;
		cmd.ncols   = ncols_q;
	end

endmodule

// ===== hdl/ggd_datapath.sv =====
// Datapath of the gradient block: two-row line store, differences, scaling
// multipliers, floor shift with saturation and the output register.
// Depends on ggd_pkg and ggd_out_if.
module ggd_datapath #(
	parameter int COLS        = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ggd_pkg::ggd_cmd_t             cmd,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [ggd_pkg::RECIP_W-1:0]   recip_x,
	input  logic [ggd_pkg::RECIP_W-1:0]   recip_y,
	output logic                          out_free,
	ggd_out_if.source                     results
);

	localparam int AW = $clog2(2 * COLS);
	localparam int DW = SAMPLE_BITS + 1;
	localparam int PW = DW + ggd_pkg::RECIP_W + 1;
	localparam logic signed [PW-1:0] SAT_HI = PW'((2 ** (ggd_pkg::GRAD_W - 1)) - 1);
	localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

	logic [SAMPLE_BITS-1:0]  mem_q [2 * COLS];
	logic [SAMPLE_BITS-1:0]  v_q;
	logic [SAMPLE_BITS-1:0]  ra_q;
	logic [SAMPLE_BITS-1:0]  rb_q;
	logic signed [DW-1:0]    dy_q;
	logic signed [DW-1:0]    dx_q;
	logic signed [PW-1:0]    py_q;
	logic signed [PW-1:0]    px_q;
	logic                    out_valid_q;

	logic                    p_par;
	logic                    c_first;
	logic                    c_last;
	logic                    shy9;
	logic                    shx9;
	logic [AW-1:0]           ya;
	logic [AW-1:0]           yb;
	logic [AW-1:0]           xa;
	logic [AW-1:0]           xb;
	logic [AW-1:0]           aa;
	logic [AW-1:0]           ab;
	logic [AW-1:0]           wa;
	logic signed [PW-1:0]    sx;
	logic signed [PW-1:0]    sy;
	logic signed [ggd_pkg::GRAD_W-1:0] gx;
	logic signed [ggd_pkg::GRAD_W-1:0] gy;

	function automatic logic [AW-1:0] loc(input logic par, input logic [ggd_pkg::COL_W-1:0] col);
		loc = (par ? AW'(COLS) : AW'(0)) + AW'(col);
	endfunction

	function automatic logic signed [ggd_pkg::GRAD_W-1:0] sat(input logic signed [PW-1:0] v);
		if (v > SAT_HI) begin
			sat = SAT_HI[ggd_pkg::GRAD_W-1:0];
		end else if (v < SAT_LO) begin
			sat = SAT_LO[ggd_pkg::GRAD_W-1:0];
		end else begin
			sat = v[ggd_pkg::GRAD_W-1:0];
		end
	endfunction

	assign p_par   = cmd.flush ? cmd.row_par : !cmd.row_par;
	assign c_first = (cmd.col == '0);
	assign c_last  = cmd.col >= (cmd.ncols - 6'd1);
	assign shy9    = !c_first && !c_last;
	assign shx9    = !cmd.flush && !cmd.row_one;

	always_comb begin
		if (c_first) begin
			ya = loc(p_par, 6'd1);
			yb = loc(p_par, 6'd0);
		end else if (c_last) begin
			ya = loc(p_par, cmd.col);
			yb = loc(p_par, cmd.col - 6'd1);
		end else begin
			ya = loc(p_par, cmd.col + 6'd1);
			yb = loc(p_par, cmd.col - 6'd1);
		end
		xa = loc(cmd.row_par, cmd.col);
		if (cmd.flush) begin
			xb = loc(!cmd.row_par, cmd.col);
		end else begin
			xb = loc(cmd.row_one ? 1'b0 : cmd.row_par, cmd.col);
		end
	end

	assign aa = cmd.rd_y ? ya : xa;
	assign ab = cmd.rd_y ? yb : xb;
	assign wa = loc(cmd.row_par, cmd.col);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[wa] <= v_q;
		end
		if (cmd.rd_y || cmd.rd_x) begin
			ra_q <= mem_q[aa];
			rb_q <= mem_q[ab];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q <= sample;
		end
		if (cmd.rd_x) begin
			dy_q <= DW'($signed(ra_q)) - DW'($signed(rb_q));
		end
		if (cmd.dif) begin
			dx_q <= (cmd.flush ? DW'($signed(ra_q)) : DW'($signed(v_q))) - DW'($signed(rb_q));
			py_q <= dy_q * $signed({1'b0, recip_y});
		end
		if (cmd.mul) begin
			px_q <= dx_q * $signed({1'b0, recip_x});
		end
	end

	assign sx = shx9 ? (px_q >>> (ggd_pkg::FRAC_SH + 1)) : (px_q >>> ggd_pkg::FRAC_SH);
	assign sy = shy9 ? (py_q >>> (ggd_pkg::FRAC_SH + 1)) : (py_q >>> ggd_pkg::FRAC_SH);
	assign gx = sat(sx);
	assign gy = sat(sy);

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			results.out_row  <= cmd.row;
			results.out_col  <= cmd.col;
			results.grad_x   <= gx;
			results.grad_y   <= gy;
			results.div_sum  <= {gx[ggd_pkg::GRAD_W-1], gx} + {gy[ggd_pkg::GRAD_W-1], gy};
			results.run_last <= cmd.last;
		end
	end

	assign results.valid = out_valid_q;

endmodule

// ===== hdl/grid_gradient_divergence_top.sv =====
// Top level of the grid gradient and divergence block: configuration
// registers on an APB-style port, controller and datapath.
// Depends on ggd_pkg, ggd_if, ggd_ctrl and ggd_datapath.
//
// Usage: grid samples enter in raster order on the samples channel, rows
// slow and columns fast. For every sample of row r >= 1 one item leaves on
// the results channel: the point of row r-1 at the same column. The sample
// that ends the last row also flushes that row, one item per column, and
// the position wraps to row 0 for the next grid. run_last marks the final
// item caused by each sample.
// Sequence: a row-0 sample is only written to the line store (S_WR); any
// other sample passes S_RDY, S_RDX, S_DIF, S_MUL, S_OUT, S_WR, and each
// flushed column S_RDY to S_OUT. A new sample is taken only in S_IDLE. The
// sequence is set by the line store, whose two read ports serve one difference
// pair per cycle, and by the two scaling multipliers that follow it.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and its result waits until the register frees.
// Reset clears position, sequencer and output valid, and loads the register
// defaults; the line store holds no reset value and is written before use.
module grid_gradient_divergence_top #(
	parameter int COLS        = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ggd_in_if.sink                        samples,
	ggd_out_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ggd_pkg::ADDR_W-1:0]    paddr,
	input  logic [ggd_pkg::DATA_W-1:0]    pwdata,
	output logic [ggd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [ggd_pkg::ROWCNT_W-1:0] row_count_q;
	logic [ggd_pkg::COL_W-1:0]    column_count_q;
	logic [ggd_pkg::RECIP_W-1:0]  recip_x_q;
	logic [ggd_pkg::RECIP_W-1:0]  recip_y_q;
	logic                         wr_en;
	logic                         out_free;
	ggd_pkg::ggd_cmd_t            cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ggd_pkg::ROW_COUNT_RST;
			column_count_q <= ggd_pkg::COL_COUNT_RST;
			recip_x_q      <= ggd_pkg::RECIP_RST;
			recip_y_q      <= ggd_pkg::RECIP_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				ggd_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[ggd_pkg::ROWCNT_W-1:0];
				ggd_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[ggd_pkg::COL_W-1:0];
				ggd_pkg::REG_RECIP_X:      recip_x_q      <= pwdata[ggd_pkg::RECIP_W-1:0];
				ggd_pkg::REG_RECIP_Y:      recip_y_q      <= pwdata[ggd_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ggd_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_q);
			ggd_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_q);
			ggd_pkg::REG_RECIP_X:      prdata = 32'(recip_x_q);
			ggd_pkg::REG_RECIP_Y:      prdata = 32'(recip_y_q);
			default:                   prdata = '0;
		endcase
	end

	ggd_ctrl #(
		.COLS(COLS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_ready     (samples.ready),
		.row_count    (row_count_q),
		.column_count (column_count_q),
		.out_free     (out_free),
		.cmd          (cmd)
	);

	ggd_datapath #(
		.COLS        (COLS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (samples.sample),
		.recip_x  (recip_x_q),
		.recip_y  (recip_y_q),
		.out_free (out_free),
		.results  (results)
	);

endmodule

// ===== hdl/ggd_checker.sv =====
// Port-level checks for the grid gradient block, bound to the top level.
// Depends on ggd_pkg and grid_gradient_divergence_top.
module ggd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ggd_pkg::ROW_W-1:0]         out_row,
	input logic [ggd_pkg::COL_W-1:0]         out_col,
	input logic signed [ggd_pkg::GRAD_W-1:0] grad_x,
	input logic signed [ggd_pkg::GRAD_W-1:0] grad_y,
	input logic signed [ggd_pkg::DIV_W-1:0]  div_sum,
	input logic                              run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(grad_x) && $stable(grad_y) && $stable(div_sum) && $stable(run_last))
		else $error("result item changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while previous item still in work");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too soon after sample");

	a_div_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> div_sum == ({grad_x[ggd_pkg::GRAD_W-1], grad_x}
			+ {grad_y[ggd_pkg::GRAD_W-1], grad_y}))
		else $error("divergence does not match gradients");

endmodule

bind grid_gradient_divergence_top ggd_checker u_ggd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_row   (results.out_row),
	.out_col   (results.out_col),
	.grad_x    (results.grad_x),
	.grad_y    (results.grad_y),
	.div_sum   (results.div_sum),
	.run_last  (results.run_last)
);
